// File: rtl/core/wpm_pkg.sv
`default_nettype none
package wpm_pkg;

	localparam int PATTERN_MAX = 32;

	localparam logic [15:0] CH_STAR     = 16'h002A;
	localparam logic [15:0] CH_QMARK    = 16'h003F;
	localparam logic [15:0] CH_UPPER_A  = 16'h0041;
	localparam logic [15:0] CH_UPPER_Z  = 16'h005A;
	localparam logic [15:0] CASE_OFFSET = 16'h0020;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_APPEND  = 2'd1,
		CMD_SUBJECT = 2'd2,
		CMD_END     = 2'd3
	} wpm_cmd_t;

	typedef struct packed {
		wpm_cmd_t    cmd;
		logic [15:0] char_code;
		logic        last;
	} wpm_req_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} wpm_rsp_t;

	typedef struct packed {
		logic        take;
		logic        clear;
		logic        append;
		logic        keep_adv;
		logic        fold;
		logic [15:0] ch;
	} wpm_ctrl_t;

	typedef struct packed {
		logic used;
		logic adv;
		logic close_a;
		logic close_r;
	} wpm_nbr_t;

	function automatic logic [15:0] fold_char(input logic [15:0] c, input logic en);
		logic [15:0] r;
		r = c;
		if (en && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/wildcard_pattern_matcher.sv
// channel   | signals                       | payload
// ----------+-------------------------------+-----------------------------
// request   | req_valid, req_ready, req     | cmd, char_code, last
// response  | rsp_valid, rsp_ready, rsp     | matched, pattern_overflow
// config    | cfg_we, cfg_wdata             | ignore_case
//
// one request per cycle while req_ready is high; responses are registered
// the cycle time is set by the star closure rippling through the row of cells
// reset (arst_n) empties the pattern and clears overflow and ignore_case
// a two-deep response buffer keeps requests flowing while rsp is stalled;
// req_ready drops only when both response slots are full
`default_nettype none
module wildcard_pattern_matcher (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire wpm_pkg::wpm_req_t  req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output wpm_pkg::wpm_rsp_t       rsp,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata
);
	import wpm_pkg::*;

	wpm_ctrl_t               ctrl;
	wpm_nbr_t                chain [0:PATTERN_MAX];
	logic [PATTERN_MAX-1:0]  end_now_v;
	logic [PATTERN_MAX-1:0]  end_adv_v;

	logic     ignore_case_q;
	logic     ovf_q;
	logic     tail_q;
	logic     take;
	logic     emit;
	logic     full;
	logic     end_a;
	logic     end_n;
	wpm_rsp_t res;
	wpm_rsp_t out_q;
	wpm_rsp_t skid_q;
	logic     out_v_q;
	logic     skid_v_q;

	assign req_ready = !skid_v_q;
	assign take      = req_valid && req_ready;
	assign full      = chain[PATTERN_MAX].used;

	always_comb begin
		ctrl.take     = take;
		ctrl.clear    = (req.cmd == CMD_CLEAR);
		ctrl.append   = (req.cmd == CMD_APPEND);
		ctrl.keep_adv = (req.cmd == CMD_SUBJECT) && !req.last;
		ctrl.fold     = ignore_case_q;
		ctrl.ch       = req.char_code;
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		wpm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.first   ((i == 0) ? 1'b1 : 1'b0),
			.ctrl    (ctrl),
			.nbr_in  (chain[i]),
			.nbr_out (chain[i+1]),
			.end_now (end_now_v[i]),
			.end_adv (end_adv_v[i])
		);
	end

	always_comb begin
		end_a = (|end_adv_v) || chain[PATTERN_MAX].adv || chain[PATTERN_MAX].close_a;
		end_n = (|end_now_v) || tail_q;
		emit  = ((req.cmd == CMD_SUBJECT) && req.last) || (req.cmd == CMD_END);
		res.matched          = (req.cmd == CMD_SUBJECT) ? end_a : end_n;
		res.pattern_overflow = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_case_q <= 1'b0;
		end else if (cfg_we) begin
			ignore_case_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q  <= 1'b0;
			tail_q <= 1'b0;
		end else if (take) begin
			if (ctrl.clear) begin
				ovf_q <= 1'b0;
			end else if (ctrl.append && full) begin
				ovf_q <= 1'b1;
			end
			tail_q <= ctrl.keep_adv ? (chain[PATTERN_MAX].adv || chain[PATTERN_MAX].close_a)
			                        : chain[PATTERN_MAX].close_r;
		end
	end

	// response buffer: output slot plus skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || rsp_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= take && emit;
			end
		end else if (take && emit) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || rsp_ready) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (take && emit) begin
			skid_q <= res;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

// File: rtl/core/wpm_cell.sv
`default_nettype none
module wpm_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              first,
	input  wire wpm_pkg::wpm_ctrl_t ctrl,
	input  wire wpm_pkg::wpm_nbr_t  nbr_in,
	output wpm_pkg::wpm_nbr_t       nbr_out,
	output logic                   end_now,
	output logic                   end_adv
);
	import wpm_pkg::*;

	logic [15:0] ch_q;
	logic        used_q;
	logic        act_q;

	logic        prev_used;
	logic        star_q;
	logic        qm_q;
	logic        hit;
	logic        write_here;
	logic        used_n;
	logic [15:0] ch_n;
	logic        star_n;
	logic        cl_a;
	logic        cl_r;

	always_comb begin
		prev_used  = first | nbr_in.used;
		star_q     = used_q && (ch_q == CH_STAR);
		qm_q       = used_q && (ch_q == CH_QMARK);
		hit        = used_q && !star_q && (qm_q || (ch_q == ctrl.ch) ||
			(fold_char(ch_q, ctrl.fold) == fold_char(ctrl.ch, ctrl.fold)));
		write_here = ctrl.append && !used_q && prev_used;
		used_n     = !ctrl.clear && (used_q || write_here);
		ch_n       = write_here ? ctrl.ch : ch_q;
		star_n     = used_n && (ch_n == CH_STAR);
		cl_a       = (act_q && star_q) || nbr_in.adv || nbr_in.close_a;
		cl_r       = first || nbr_in.close_r;

		nbr_out.used    = used_q;
		nbr_out.adv     = act_q && hit;
		nbr_out.close_a = cl_a && star_q;
		nbr_out.close_r = cl_r && star_n;

		end_now = act_q && !used_q;
		end_adv = cl_a && !used_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= first;
			used_q <= 1'b0;
		end else if (ctrl.take) begin
			act_q  <= ctrl.keep_adv ? cl_a : cl_r;
			used_q <= used_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take && write_here) begin
			ch_q <= ctrl.ch;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/wpm_checker.sv
`default_nettype none
module wpm_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire wpm_pkg::wpm_req_t  req,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire wpm_pkg::wpm_rsp_t  rsp
);
	import wpm_pkg::*;

	// a stalled response stays up and unchanged
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	// a new response needs an accepted request
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready))
		else $error("response without request");

	// end request into an empty output gives a response next cycle
	a_end_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.cmd == CMD_END && !rsp_valid |=> rsp_valid)
		else $error("end request gave no response");

	// back-pressure only with a response waiting
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid)
		else $error("request stalled with no response pending");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (.*);
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wpm_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int SESSION_ITEMS = 275;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	wpm_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	wpm_rsp_t rsp;
	logic     cfg_we = 1'b0;
	logic     cfg_wdata = 1'b0;

	wildcard_pattern_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	wpm_req_t requests_to_send [$];
	wpm_rsp_t expected_verdicts [$];
	wpm_rsp_t oldest_verdict;
	int       queued_count = 0;
	int       mismatches = 0;
	int       quiet_cycles = 0;
	int       send_idle = 0;
	int       recv_idle = 0;
	logic     req_taken = 1'b0;

	// matcher state
	logic [15:0]          pat_chars [PATTERN_MAX];
	int unsigned          pat_len = 0;
	logic [PATTERN_MAX:0] live_pos = 1;
	logic                 ovf_seen = 1'b0;
	logic                 fold_en = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [15:0] fold_case(input logic [15:0] c);
		if (fold_en && c[15:5] == 11'h002 && c[4:0] >= 5'd1 && c[4:0] <= 5'd26) begin
			return {c[15:6], 1'b1, c[4:0]};
		end
		return c;
	endfunction

	task automatic close_stars();
		for (int i = 0; i < pat_len; i++) begin
			if (live_pos[i] && pat_chars[i] == CH_STAR) begin
				live_pos[i + 1] = 1'b1;
			end
		end
	endtask

	task automatic restart_positions();
		live_pos = '0;
		live_pos[0] = 1'b1;
		close_stars();
	endtask

	task automatic step_positions(input logic [15:0] c);
		logic [PATTERN_MAX:0] nxt;
		nxt = '0;
		for (int i = 0; i < pat_len; i++) begin
			if (live_pos[i]) begin
				if (pat_chars[i] == CH_STAR) begin
					nxt[i] = 1'b1;
				end else if (pat_chars[i] == CH_QMARK || fold_case(pat_chars[i]) == fold_case(c)) begin
					nxt[i + 1] = 1'b1;
				end
			end
		end
		live_pos = nxt;
		close_stars();
	endtask

	task automatic predict_match(input wpm_req_t r);
		wpm_rsp_t v;
		case (r.cmd)
			CMD_CLEAR: begin
				pat_len = 0;
				ovf_seen = 1'b0;
				restart_positions();
				return;
			end
			CMD_APPEND: begin
				if (pat_len < PATTERN_MAX) begin
					pat_chars[pat_len] = r.char_code;
					pat_len++;
				end else begin
					ovf_seen = 1'b1;
				end
				restart_positions();
				return;
			end
			CMD_SUBJECT: begin
				step_positions(r.char_code);
				if (!r.last) begin
					return;
				end
			end
			default: begin
			end
		endcase
		v.matched = live_pos[pat_len];
		v.pattern_overflow = ovf_seen;
		expected_verdicts.push_back(v);
		restart_positions();
	endtask

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// driver
	always @(negedge clk) begin
		if (!req_valid || req_taken) begin
			if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
				req <= requests_to_send.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
		rsp_ready <= ($urandom_range(99) >= recv_idle);
	end

	// monitor, scoreboard and watchdog
	always @(posedge clk) begin
		req_taken = req_valid && req_ready;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_verdicts.size() == 0) begin
					flag_mismatch("response with nothing outstanding");
				end else begin
					oldest_verdict = expected_verdicts.pop_front();
					if (rsp.matched !== oldest_verdict.matched) begin
						flag_mismatch($sformatf("matched got %b want %b",
							rsp.matched, oldest_verdict.matched));
					end
					if (rsp.pattern_overflow !== oldest_verdict.pattern_overflow) begin
						flag_mismatch($sformatf("pattern_overflow got %b want %b",
							rsp.pattern_overflow, oldest_verdict.pattern_overflow));
					end
				end
			end
			if (req_taken) begin
				predict_match(req);
			end
			if (req_taken || (rsp_valid && rsp_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic queue_req(input wpm_cmd_t c, input logic [15:0] ch, input logic l);
		wpm_req_t r;
		r.cmd = c;
		r.char_code = ch;
		r.last = l;
		requests_to_send.push_back(r);
		queued_count++;
	endtask

	function automatic logic [15:0] pattern_char();
		int r;
		r = $urandom_range(99);
		if (r < 25) begin
			return CH_STAR;
		end else if (r < 40) begin
			return CH_QMARK;
		end else if (r < 85) begin
			case ($urandom_range(3))
				0: return 16'h0041;
				1: return 16'h0042;
				2: return 16'h0061;
				default: return 16'h0062;
			endcase
		end
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] subject_char();
		if ($urandom_range(99) < 70) begin
			case ($urandom_range(5))
				0: return 16'h0041;
				1: return 16'h0042;
				2: return 16'h0061;
				3: return 16'h0062;
				4: return CH_STAR;
				default: return CH_QMARK;
			endcase
		end
		return 16'($urandom);
	endfunction

	task automatic queue_session();
		logic [15:0] pat [$];
		logic [15:0] subj [$];
		logic [15:0] c;
		int          n_pat;
		logic        early_end;
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(6, 1)) begin
				queue_req(wpm_cmd_t'(2'($urandom)), 16'($urandom), 1'($urandom));
			end
			return;
		end
		queue_req(CMD_CLEAR, 16'($urandom), 1'($urandom));
		n_pat = ($urandom_range(9) == 0) ? $urandom_range(36, 28) : $urandom_range(10);
		repeat (n_pat) begin
			pat.push_back(pattern_char());
			queue_req(CMD_APPEND, pat[$], 1'($urandom));
		end
		repeat ($urandom_range(4, 1)) begin
			subj.delete();
			if ($urandom_range(99) < 60) begin
				foreach (pat[i]) begin
					c = pat[i];
					if (i >= PATTERN_MAX) begin
						break;
					end else if (c == CH_STAR) begin
						repeat ($urandom_range(3)) subj.push_back(subject_char());
					end else if (c == CH_QMARK) begin
						subj.push_back(subject_char());
					end else begin
						if (((c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A))
								&& $urandom_range(3) == 0) begin
							c[5] = ~c[5];
						end
						subj.push_back(c);
					end
				end
			end else begin
				repeat ($urandom_range(8)) subj.push_back(subject_char());
			end
			if (subj.size() != 0 && $urandom_range(9) == 0) begin
				subj[$urandom_range(subj.size() - 1)] = subject_char();
			end
			early_end = ($urandom_range(9) == 0);
			if (subj.size() == 0) begin
				queue_req(CMD_END, 16'($urandom), 1'($urandom));
			end else begin
				foreach (subj[i]) begin
					queue_req(CMD_SUBJECT, subj[i], (i == subj.size() - 1) && !early_end);
				end
				if (early_end) begin
					queue_req(CMD_END, 16'($urandom), 1'($urandom));
				end
			end
		end
	endtask

	task automatic drain();
		do begin
			@(negedge clk);
		end while (requests_to_send.size() != 0 || req_valid || expected_verdicts.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_ignore_case(input logic v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		fold_en = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		send_idle = 11;
		recv_idle = 86;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_ignore_case(1'b0);
		@(posedge clk);
		// empty pattern, lone star, ignored fields
		queue_req(CMD_END, 16'h0000, 1'b0);
		queue_req(CMD_SUBJECT, 16'h0000, 1'b1);
		queue_req(CMD_APPEND, CH_STAR, 1'b1);
		queue_req(CMD_END, 16'hFFFF, 1'b1);
		queue_req(CMD_SUBJECT, 16'hFFFF, 1'b1);
		queue_req(CMD_CLEAR, 16'hFFFF, 1'b1);
		// pattern A?*<ffff>
		queue_req(CMD_APPEND, 16'h0041, 1'b0);
		queue_req(CMD_APPEND, CH_QMARK, 1'b0);
		queue_req(CMD_APPEND, CH_STAR, 1'b0);
		queue_req(CMD_APPEND, 16'hFFFF, 1'b0);
		queue_req(CMD_SUBJECT, 16'h0061, 1'b0);
		queue_req(CMD_SUBJECT, 16'h0000, 1'b1);
		queue_req(CMD_SUBJECT, 16'h0041, 1'b0);
		queue_req(CMD_SUBJECT, CH_STAR, 1'b0);
		queue_req(CMD_SUBJECT, 16'h0000, 1'b0);
		queue_req(CMD_SUBJECT, 16'hFFFF, 1'b1);
		// end in mid-subject
		queue_req(CMD_SUBJECT, 16'h0041, 1'b0);
		queue_req(CMD_END, 16'h0000, 1'b0);
		queue_req(CMD_SUBJECT, 16'h0041, 1'b0);
		queue_req(CMD_SUBJECT, CH_QMARK, 1'b0);
		queue_req(CMD_SUBJECT, 16'hFFFF, 1'b1);
		queue_req(CMD_APPEND, 16'h0000, 1'b0);
		queue_req(CMD_END, 16'h0000, 1'b0);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle = 86;
				recv_idle = 11;
			end else if (ph == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_ignore_case(ph % 2 == 0);
			@(posedge clk);
			queued_count = 0;
			while (queued_count < SESSION_ITEMS) begin
				queue_session();
			end
			drain();
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire
